// ----- rtl/epld_pkg.sv -----
package epld_pkg;

    // Longest path decoded; later bytes are dropped until the final mark.
    localparam int MAX_PATH_BYTES = 255;
    localparam int BYTE_CNT_W     = $clog2(MAX_PATH_BYTES + 1);

    localparam logic [6:0] SEG_COUNT_MAX = 7'd127;

    // Logical segment headers
    localparam logic [7:0] SEG_CLASS_8   = 8'h20;
    localparam logic [7:0] SEG_INST_8    = 8'h24;
    localparam logic [7:0] SEG_ATTR_8    = 8'h30;
    localparam logic [7:0] SEG_CLASS_16  = 8'h21;
    localparam logic [7:0] SEG_INST_16   = 8'h25;
    localparam logic [7:0] SEG_ATTR_16   = 8'h31;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_VAL8   = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_HIGH   = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_CLASS = 2'd1,
        KIND_INST  = 2'd2,
        KIND_ATTR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       final_byte;
    } path_beat_t;

    typedef struct packed {
        logic        malformed;
        logic [15:0] cls_value;
        logic [15:0] inst_value;
        logic [15:0] attribute_value;
        logic [6:0]  segment_count;
    } result_beat_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic at_reset;   // parse phase, counts and malformed flag back at post-reset values
        logic in_segment; // header taken, value bytes still pending
    } parse_status_t;

endpackage

// ----- rtl/epld_in_reg.sv -----
module epld_in_reg
    import epld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       path_valid,
    output logic       path_ready,
    input  path_beat_t path_data,
    input  logic       take,
    output logic       held_valid,
    output path_beat_t held_data
);

    logic       valid_reg;
    logic       valid_next;
    path_beat_t data_reg;

    // Refill in the same cycle the held beat moves on.
    assign path_ready = !valid_reg || take;
    assign valid_next = path_ready ? path_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_valid && path_ready)
        begin
            data_reg <= path_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

// ----- rtl/epld_parser.sv -----
module epld_parser
    import epld_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  path_beat_t    beat,
    output result_beat_t  result,
    output parse_status_t status
);

    phase_t                phase_reg, phase_next, phase_upd;
    kind_t                 kind_reg, kind_next, kind_upd;
    logic [7:0]            low_reg, low_next, low_upd;
    logic [15:0]           class_reg, class_next, class_upd;
    logic [15:0]           inst_reg, inst_next, inst_upd;
    logic [15:0]           attr_reg, attr_next, attr_upd;
    logic [6:0]            count_reg, count_next, count_upd;
    logic [BYTE_CNT_W-1:0] bcnt_reg, bcnt_next, bcnt_upd;
    logic                  bad_reg, bad_next, bad_upd;
    logic                  last;
    logic                  store_en;
    logic [15:0]           store_val;

    // Byte that reaches the length limit decodes as the last one.
    assign last = beat.final_byte || (bcnt_reg == BYTE_CNT_W'(MAX_PATH_BYTES - 1));

    always_comb
    begin
        phase_upd = phase_reg;
        kind_upd  = kind_reg;
        low_upd   = low_reg;
        bad_upd   = bad_reg;
        bcnt_upd  = bcnt_reg;
        store_en  = 1'b0;
        store_val = {8'h00, beat.path_byte};
        if (bcnt_reg < BYTE_CNT_W'(MAX_PATH_BYTES))
        begin
            bcnt_upd = bcnt_reg + 1'b1;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (!last)
                    begin
                        unique case (beat.path_byte)
                            SEG_CLASS_8:  begin kind_upd = KIND_CLASS; phase_upd = PH_VAL8; end
                            SEG_INST_8:   begin kind_upd = KIND_INST;  phase_upd = PH_VAL8; end
                            SEG_ATTR_8:   begin kind_upd = KIND_ATTR;  phase_upd = PH_VAL8; end
                            SEG_CLASS_16: begin kind_upd = KIND_CLASS; phase_upd = PH_LOW;  end
                            SEG_INST_16:  begin kind_upd = KIND_INST;  phase_upd = PH_LOW;  end
                            SEG_ATTR_16:  begin kind_upd = KIND_ATTR;  phase_upd = PH_LOW;  end
                            default:      phase_upd = PH_HEADER;
                        endcase
                    end
                end
                PH_VAL8:
                begin
                    store_en  = 1'b1;
                    phase_upd = PH_HEADER;
                end
                PH_LOW:
                begin
                    if (last)
                    begin
                        bad_upd   = 1'b1;
                        phase_upd = PH_HEADER;
                    end
                    else
                    begin
                        low_upd   = beat.path_byte;
                        phase_upd = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    store_en  = 1'b1;
                    store_val = {beat.path_byte, low_reg};
                    phase_upd = PH_HEADER;
                end
                default:
                begin
                    phase_upd = PH_HEADER;
                end
            endcase
        end
    end

    always_comb
    begin
        class_upd = class_reg;
        inst_upd  = inst_reg;
        attr_upd  = attr_reg;
        count_upd = count_reg;
        if (store_en)
        begin
            unique case (kind_reg)
                KIND_CLASS: class_upd = store_val;
                KIND_INST:  inst_upd  = store_val;
                KIND_ATTR:  attr_upd  = store_val;
                default:    class_upd = class_reg;
            endcase
            if (count_reg < SEG_COUNT_MAX)
            begin
                count_upd = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        result.malformed       = bad_upd;
        result.cls_value       = class_upd;
        result.inst_value      = inst_upd;
        result.attribute_value = attr_upd;
        result.segment_count   = count_upd;
    end

    // Final beat flushes the path state.
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        low_next   = low_reg;
        class_next = class_reg;
        inst_next  = inst_reg;
        attr_next  = attr_reg;
        count_next = count_reg;
        bcnt_next  = bcnt_reg;
        bad_next   = bad_reg;
        if (step)
        begin
            if (beat.final_byte)
            begin
                phase_next = PH_HEADER;
                kind_next  = KIND_NONE;
                low_next   = '0;
                class_next = '0;
                inst_next  = '0;
                attr_next  = '0;
                count_next = '0;
                bcnt_next  = '0;
                bad_next   = 1'b0;
            end
            else
            begin
                phase_next = phase_upd;
                kind_next  = kind_upd;
                low_next   = low_upd;
                class_next = class_upd;
                inst_next  = inst_upd;
                attr_next  = attr_upd;
                count_next = count_upd;
                bcnt_next  = bcnt_upd;
                bad_next   = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            kind_reg  <= KIND_NONE;
            low_reg   <= '0;
            class_reg <= '0;
            inst_reg  <= '0;
            attr_reg  <= '0;
            count_reg <= '0;
            bcnt_reg  <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            low_reg   <= low_next;
            class_reg <= class_next;
            inst_reg  <= inst_next;
            attr_reg  <= attr_next;
            count_reg <= count_next;
            bcnt_reg  <= bcnt_next;
            bad_reg   <= bad_next;
        end
    end

    assign status.at_reset   = (phase_reg == PH_HEADER) && (count_reg == '0)
                               && (bcnt_reg == '0) && !bad_reg;
    assign status.in_segment = (phase_reg != PH_HEADER);

endmodule

// ----- rtl/epld_out_reg.sv -----
module epld_out_reg
    import epld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_beat_t load_data,
    output logic         slot_free,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_data
);

    logic         valid_reg;
    logic         valid_next;
    result_beat_t data_reg;

    assign slot_free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

// ----- rtl/epath_logical_segment_decoder.sv -----
// Logical segment path decoder. Path bytes arrive one beat at a time on the
// path channel, final_byte marking the last byte of a path. 8-bit segments
// (class 0x20, instance 0x24, attribute 0x30) take one value byte; 16-bit
// segments (0x21, 0x25, 0x31) take low byte then high byte. Unknown bytes are
// skipped, a header on the final byte is ignored, and a 16-bit segment cut
// short by the end of the path sets malformed. Only the first MAX_PATH_BYTES
// bytes of a path are decoded. One result beat leaves per path, on the final
// byte, carrying the last id of each kind (0 if none) and the saturating
// segment count. Rate: one byte per clock sustained; the single parse state
// update sits between the input register and the result register. When the
// result slot is free, a held final byte passes into the result register,
// raising result_valid. A final byte waits in the input register while an
// older result is still unclaimed; non-final bytes keep flowing regardless.
module epath_logical_segment_decoder
    import epld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         path_valid,
    output logic         path_ready,
    input  path_beat_t   path_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_data
);

    logic          held_valid;
    path_beat_t    held_data;
    logic          advance;
    logic          load;
    logic          slot_free;
    result_beat_t  parse_result;
    parse_status_t parse_status;

    // Input register: one beat parked ahead of the parser.
    epld_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .path_valid (path_valid),
        .path_ready (path_ready),
        .path_data  (path_data),
        .take       (advance),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    // A held beat moves into the parser unless it is a final byte whose
    // result has nowhere to go yet.
    assign advance = held_valid && (!held_data.final_byte || slot_free);
    assign load    = advance && held_data.final_byte;

    epld_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .beat   (held_data),
        .result (parse_result),
        .status (parse_status)
    );

    // Result register decouples the result consumer from the byte stream.
    epld_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .load_data    (parse_result),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // Final byte must not overwrite an unclaimed result.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("result overwritten before it was taken");

    // After a path closes, the parse state is back at reset.
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> parse_status.at_reset)
        else $error("parse state not cleared after final byte");

    // Every closed path shows up on the result port.
    a_result_up: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid)
        else $error("final byte produced no result");

    // An empty input register always takes a new beat.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid |-> path_ready)
        else $error("input stalled while empty");

endmodule
